/* hdl/tpfp_pkg.sv */
// Shared types and constants for the triangle plane unit.
// Depends on nothing; the top module refers to it by scoped names, the cells do not use it.
package tpfp_pkg;

	// One input transaction: three points in signed Q16.16.
	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
	} tri_in_t;

	// One result transaction: unit normal in Q2.30 and offset in signed Q24.16.
	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [39:0] plane_offset;
		logic               degenerate;
	} plane_out_t;

	// Squared cross length at or below this value marks a degenerate triangle.
	localparam logic [63:0] DEGEN_SQ_MAX = 64'd18446743;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam int SQRT_CELLS = 32;
	localparam int DIV_CELLS = 32;

endpackage

/* hdl/tpfp_sqrt_cell.sv */
// One restoring square-root step; a row of these forms the root pipeline.
// Depends on nothing but its own ports.
module tpfp_sqrt_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rem_in,
	input  logic [63:0] root_in,
	input  logic [63:0] bit_in,
	output logic [63:0] rem_out,
	output logic [63:0] root_out,
	output logic [63:0] bit_out
);

	logic [63:0] trial;
	logic        take;

	// Compare the remainder against root plus the current bit.
	assign trial = root_in + bit_in;
	assign take  = rem_in >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? rem_in - trial : rem_in;
			root_out <= take ? (root_in >> 1) + bit_in : root_in >> 1;
			bit_out  <= bit_in >> 2;
		end
	end

endmodule

/* hdl/tpfp_div_cell.sv */
// One restoring division step for the three normal components at once.
// Depends on nothing but its own ports.
module tpfp_div_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] den,
	input  logic [32:0] rem_in  [3],
	input  logic [62:0] num_in  [3],
	input  logic [32:0] quo_in  [3],
	output logic [32:0] rem_out [3],
	output logic [62:0] num_out [3],
	output logic [32:0] quo_out [3]
);

	logic [33:0] shifted [3];
	logic [33:0] diff    [3];

	// Bring down one numerator bit and try subtracting the divisor.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shifted[i] = {rem_in[i], num_in[i][62]};
			diff[i]    = shifted[i] - {2'b00, den};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_out[i] <= diff[i][33] ? shifted[i][32:0] : diff[i][32:0];
				quo_out[i] <= {quo_in[i][31:0], ~diff[i][33]};
				num_out[i] <= {num_in[i][61:0], 1'b0};
			end
		end
	end

endmodule

/* hdl/triangle_plane_from_points.sv */
// Triangle plane unit: one triangle per cycle while the output is not stalled.
// Pipeline: 74 register stages, namely 6 front stages, 32 square-root cells, 1 divisor
// stage, 33 division cells and 2 offset stages; the first is loaded at the accepting edge.
// Throughput is one transaction per cycle, set by the fully pipelined chains of root and
// division cells; a stall freezes the chain.
// Reset clears the valid bits of every stage; the payload is not reset.
module triangle_plane_from_points (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tpfp_pkg::tri_in_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tpfp_pkg::plane_out_t out_data
);

	localparam int NSQ = tpfp_pkg::SQRT_CELLS;
	localparam int NDV = tpfp_pkg::DIV_CELLS + 1;
	localparam int DEPTH = 6 + NSQ + 1 + NDV + 2;

	// Per-item context carried alongside the arithmetic chains.
	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic [2:0]         neg;
		logic               degen;
	} ctx_t;

	logic             adv;
	logic [DEPTH-1:0] vld_q;
	ctx_t             ctx_q [DEPTH];

	// The whole pipeline moves when the output register is free or being taken.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// Stage 1: edge vectors v = B - C, w = A - B.
	logic signed [32:0] v_s1 [3];
	logic signed [32:0] w_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1[0] <= 33'(in_data.b_x) - 33'(in_data.c_x);
			v_s1[1] <= 33'(in_data.b_y) - 33'(in_data.c_y);
			v_s1[2] <= 33'(in_data.b_z) - 33'(in_data.c_z);
			w_s1[0] <= 33'(in_data.a_x) - 33'(in_data.b_x);
			w_s1[1] <= 33'(in_data.a_y) - 33'(in_data.b_y);
			w_s1[2] <= 33'(in_data.a_z) - 33'(in_data.b_z);
		end
	end

	// Stage 2: six products, each registered.
	logic signed [65:0] pr_s2 [6];
	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s2[0] <= 66'(v_s1[1]) * 66'(w_s1[2]);
			pr_s2[1] <= 66'(v_s1[2]) * 66'(w_s1[1]);
			pr_s2[2] <= 66'(v_s1[2]) * 66'(w_s1[0]);
			pr_s2[3] <= 66'(v_s1[0]) * 66'(w_s1[2]);
			pr_s2[4] <= 66'(v_s1[0]) * 66'(w_s1[1]);
			pr_s2[5] <= 66'(v_s1[1]) * 66'(w_s1[0]);
		end
	end

	// Stage 3: cross product magnitudes and signs.
	logic signed [66:0] crs [3];
	logic [66:0]        mag_s3 [3];
	logic [2:0]         neg_s3;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			crs[i] = 67'(pr_s2[2*i]) - 67'(pr_s2[2*i+1]);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= crs[i][66];
				mag_s3[i] <= crs[i][66] ? 67'(-crs[i]) : 67'(crs[i]);
			end
		end
	end

	// Stage 4: bit length of the largest magnitude, found on the OR of all three.
	logic [66:0] orm;
	logic [6:0]  len_c;
	logic [6:0]  bl_s4;
	logic [66:0] mag_s4 [3];
	logic [2:0]  neg_s4;
	always_comb begin
		orm   = mag_s3[0] | mag_s3[1] | mag_s3[2];
		len_c = '0;
		for (int b = 0; b < 67; b++) begin
			if (orm[b]) len_c = 7'(b + 1);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			bl_s4  <= len_c;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
		end
	end

	// Stage 5: scale to 31 bits and square the small case for the degenerate test.
	logic [30:0] r_s5 [3];
	logic [61:0] sq_s5 [3];
	logic        small_s5;
	logic [2:0]  neg_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			small_s5 <= bl_s4 <= 7'd31;
			neg_s5   <= neg_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= mag_s4[i][30:0] * mag_s4[i][30:0];
				if (bl_s4 <= 7'd31)
					r_s5[i] <= 31'(mag_s4[i] << (7'd31 - bl_s4));
				else
					r_s5[i] <= 31'(mag_s4[i] >> (bl_s4 - 7'd31));
			end
		end
	end

	// Stage 6: squares of the scaled components; the degenerate flag joins the context.
	logic [61:0] rs_s6 [3];
	logic [30:0] r_s6  [3];
	logic        dg_c;
	assign dg_c = small_s5 && ({2'b00, sq_s5[0]} + {2'b00, sq_s5[1]}
		+ {2'b00, sq_s5[2]} <= tpfp_pkg::DEGEN_SQ_MAX);
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				rs_s6[i] <= r_s5[i] * r_s5[i];
			end
			r_s6 <= r_s5;
		end
	end

	// Context follows the pipeline one register per stage; the signs join after stage 4
	// and the degenerate flag after stage 5.
	ctx_t ctx_d [DEPTH];
	always_comb begin
		ctx_d[0] = '{ax: in_data.a_x, ay: in_data.a_y, az: in_data.a_z,
			neg: 3'b000, degen: 1'b0};
		for (int k = 1; k < DEPTH; k++) begin
			ctx_d[k] = ctx_q[k-1];
		end
		ctx_d[4].neg   = neg_s4;
		ctx_d[5].degen = dg_c;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_q <= ctx_d;
		end
	end

	// Square-root chain; the scaled components ride along it.
	logic [63:0] sr_rem  [NSQ+1];
	logic [63:0] sr_root [NSQ+1];
	logic [63:0] sr_bit  [NSQ+1];
	logic [30:0] rq_q    [NSQ+1][3];
	assign sr_rem[0]  = {2'b00, rs_s6[0]} + {2'b00, rs_s6[1]} + {2'b00, rs_s6[2]};
	assign sr_root[0] = '0;
	assign sr_bit[0]  = 64'h4000_0000_0000_0000;
	assign rq_q[0]    = r_s6;

	for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
		tpfp_sqrt_cell u_cell (
			.clk      (clk),
			.en       (adv),
			.rem_in   (sr_rem[g]),
			.root_in  (sr_root[g]),
			.bit_in   (sr_bit[g]),
			.rem_out  (sr_rem[g+1]),
			.root_out (sr_root[g+1]),
			.bit_out  (sr_bit[g+1])
		);
		always_ff @(posedge clk) begin
			if (adv) rq_q[g+1] <= rq_q[g];
		end
	end

	// Divisor stage: numerators r*2^30 + len/2. The part above the low 33 bits is
	// already below the divisor, so it seeds the remainder and the chain takes the rest.
	logic [31:0] den_q   [NDV+1];
	logic [32:0] dv_rem  [NDV+1][3];
	logic [62:0] dv_num  [NDV+1][3];
	logic [32:0] dv_quo  [NDV+1][3];
	logic [61:0] numer   [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			numer[i] = {1'b0, rq_q[NSQ][i], 30'd0} + 62'(sr_root[NSQ][31:1]);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			den_q[0] <= sr_root[NSQ][31:0];
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= 33'(numer[i][61:33]);
				dv_quo[0][i] <= '0;
				dv_num[0][i] <= {numer[i][32:0], 30'd0};
			end
		end
	end

	for (genvar g = 0; g < NDV; g++) begin : g_div
		tpfp_div_cell u_cell (
			.clk     (clk),
			.en      (adv),
			.den     (den_q[g]),
			.rem_in  (dv_rem[g]),
			.num_in  (dv_num[g]),
			.quo_in  (dv_quo[g]),
			.rem_out (dv_rem[g+1]),
			.num_out (dv_num[g+1]),
			.quo_out (dv_quo[g+1])
		);
		always_ff @(posedge clk) begin
			if (adv) den_q[g+1] <= den_q[g];
		end
	end

	// Offset stage 1: saturate, sign (or zero for a degenerate triangle), and form the three products.
	ctx_t               oc;
	logic signed [32:0] nv    [3];
	logic signed [32:0] n_s7  [3];
	logic signed [64:0] pd_s7 [3];
	logic [32:0]        qsat  [3];
	assign oc = ctx_q[DEPTH-3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qsat[i] = dv_quo[NDV][i];
			if (qsat[i] > 33'(tpfp_pkg::ONE_Q30)) qsat[i] = 33'(tpfp_pkg::ONE_Q30);
			nv[i] = oc.degen ? 33'sd0 : (oc.neg[i] ? -$signed(qsat[i]) : $signed(qsat[i]));
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				n_s7[i] <= nv[i];
			end
			pd_s7[0] <= 65'(nv[0]) * 65'(oc.ax);
			pd_s7[1] <= 65'(nv[1]) * 65'(oc.ay);
			pd_s7[2] <= 65'(nv[2]) * 65'(oc.az);
		end
	end

	// Offset stage 2: sum, round half away, negate.
	logic signed [66:0] dot;
	logic [66:0]        dmag;
	logic [66:0]        dq;
	always_comb begin
		dot  = 67'(pd_s7[0]) + 67'(pd_s7[1]) + 67'(pd_s7[2]);
		dmag = dot[66] ? 67'(-dot) : 67'(dot);
		dq   = (dmag + (67'd1 << 29)) >> 30;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.normal_x     <= 32'(n_s7[0]);
			out_data.normal_y     <= 32'(n_s7[1]);
			out_data.normal_z     <= 32'(n_s7[2]);
			out_data.plane_offset <= (!dot[66] && dot != 0) ? -40'(dq) : 40'(dq);
			out_data.degenerate   <= ctx_q[DEPTH-2].degen;
		end
	end

	assign out_valid = vld_q[DEPTH-1];

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready out of step with output");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.plane_offset == 0
		&& out_data.normal_x == 0)
		else $error("degenerate result not zero");
`endif

endmodule
